// ----- src/sorted_leaf_table_top_macros.svh -----
// Assertion macros for the sorted leaf table top level.
// Uses the i_clk and i_rst_n names of the including module.
`ifndef SORTED_LEAF_TABLE_TOP_MACROS_SVH
`define SORTED_LEAF_TABLE_TOP_MACROS_SVH

`define SLT_CHK_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define SLT_CHK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/slt_pkg.sv -----
// Shared types and codes for the sorted leaf table.
// No dependencies.
`default_nettype none

package slt_pkg;

    localparam int VALUE_BITS = 64;
    localparam int KEY_FIELD_BITS = 64;
    localparam int COUNT_FIELD_BITS = 7;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_LOOKUP = 2'd1,
        CMD_REMOVE = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        ST_DONE = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    typedef struct packed {
        logic [1:0]                command;
        logic [KEY_FIELD_BITS-1:0] key;
        logic [VALUE_BITS-1:0]     entry_value;
    } t_in_word;

    typedef struct packed {
        logic [1:0]                  status;
        logic [VALUE_BITS-1:0]       found_value;
        logic [COUNT_FIELD_BITS-1:0] entry_count;
    } t_out_word;

    typedef struct packed {
        logic cmp_en;
        logic ins;
        logic del;
    } t_cell_ctl;

endpackage

`default_nettype wire

// ----- src/slt_cell.sv -----
// One slot of the sorted table: holds a key/value pair, compares it
// against the incoming word and shifts with its neighbors. Uses slt_pkg.
`default_nettype none

module slt_cell #(
    parameter int KEY_BITS = 64
) (
    input  logic                          i_clk,
    input  slt_pkg::t_cell_ctl            i_ctl,
    input  logic                          i_occupied,
    input  logic [KEY_BITS-1:0]           i_cmp_key,
    input  logic [slt_pkg::VALUE_BITS-1:0] i_cmp_value,
    input  logic [KEY_BITS-1:0]           i_new_key,
    input  logic [slt_pkg::VALUE_BITS-1:0] i_new_value,
    input  logic                          i_left_lt,
    input  logic [KEY_BITS-1:0]           i_left_key,
    input  logic [slt_pkg::VALUE_BITS-1:0] i_left_value,
    input  logic [KEY_BITS-1:0]           i_right_key,
    input  logic [slt_pkg::VALUE_BITS-1:0] i_right_value,
    input  logic                          i_take_right,
    output logic                          o_lt,
    output logic                          o_eq,
    output logic                          o_vm,
    output logic [KEY_BITS-1:0]           o_key,
    output logic [slt_pkg::VALUE_BITS-1:0] o_value
);
    import slt_pkg::*;

    logic [KEY_BITS-1:0]   r_key;
    logic [VALUE_BITS-1:0] r_value;
    logic                  r_lt;
    logic                  r_eq;
    logic                  r_vm;

    always_ff @(posedge i_clk) begin
        if (i_ctl.cmp_en) begin
            r_lt <= i_occupied && (r_key < i_cmp_key);
            r_eq <= i_occupied && (r_key == i_cmp_key);
            r_vm <= (r_value == i_cmp_value);
        end
        if (i_ctl.ins && !r_lt) begin
            if (i_left_lt) begin
                r_key   <= i_new_key;
                r_value <= i_new_value;
            end else begin
                r_key   <= i_left_key;
                r_value <= i_left_value;
            end
        end else if (i_ctl.del && i_take_right) begin
            r_key   <= i_right_key;
            r_value <= i_right_value;
        end
    end

    assign o_lt    = r_lt;
    assign o_eq    = r_eq;
    assign o_vm    = r_vm;
    assign o_key   = r_key;
    assign o_value = r_value;

endmodule

`default_nettype wire

// ----- src/sorted_leaf_table_top.sv -----
// Sorted leaf table: a row of slot cells, each comparing its pair in parallel.
// The result word is registered when the exec state commits the word accepted in idle;
// a new word is taken only in the idle state (compare in the cell row, then shift/commit),
// and the exec state holds while the output register is stalled.
// Reset: i_rst_n synchronous active low; clears the entry count and handshake state.
`default_nettype none
`include "sorted_leaf_table_top_macros.svh"

module sorted_leaf_table_top #(
    parameter int CAPACITY = 64,
    parameter int KEY_BITS = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  slt_pkg::t_in_word  i_word,
    output logic               o_valid,
    input  logic               i_ready,
    output slt_pkg::t_out_word o_word
);
    import slt_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    t_state                r_state;
    t_state                n_state;
    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      n_count;
    logic [1:0]            r_cmd;
    logic [KEY_BITS-1:0]   r_key;
    logic [VALUE_BITS-1:0] r_value;
    logic                  r_out_valid;
    t_out_word             r_out;
    t_out_word             n_out;

    logic                  w_accept;
    logic                  w_slot_free;
    logic                  w_commit;
    logic                  w_full;
    logic                  w_do_ins;
    logic                  w_do_del;
    logic                  w_any_eq;
    logic                  w_any_hit;
    logic [VALUE_BITS-1:0] w_found;
    t_cell_ctl             w_ctl;
    logic [CNT_W+COUNT_FIELD_BITS-1:0] w_cnt_ext;

    logic [CAPACITY-1:0]   w_lt;
    logic [CAPACITY-1:0]   w_eq;
    logic [CAPACITY-1:0]   w_vm;
    logic [CAPACITY-1:0]   w_left_lt;
    logic [CAPACITY-1:0]   w_first_eq;
    logic [CAPACITY-1:0]   w_hit;
    logic [CAPACITY-1:0]   w_take_right;
    logic [CAPACITY-1:0]   w_occ;
    logic [KEY_BITS-1:0]   w_key   [CAPACITY];
    logic [VALUE_BITS-1:0] w_val   [CAPACITY];

    assign w_slot_free = !r_out_valid || i_ready;
    assign w_full      = (r_count == CNT_W'(CAPACITY));

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) n_state = S_EXEC;
            end
            S_EXEC: begin
                if (w_slot_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ready  = 1'b0;
        w_commit = 1'b0;
        case (r_state)
            S_IDLE:  o_ready  = 1'b1;
            S_EXEC:  w_commit = w_slot_free;
            default: o_ready  = 1'b0;
        endcase
    end

    assign w_accept = i_valid && o_ready;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            localparam logic [CNT_W-1:0] IDX = CNT_W'(g);
            localparam logic [CAPACITY-1:0] UPTO = {CAPACITY{1'b1}} >> (CAPACITY - 1 - g);

            assign w_occ[g]        = IDX < r_count;
            assign w_first_eq[g]   = w_eq[g] && w_left_lt[g];
            assign w_hit[g]        = w_eq[g] && w_vm[g];
            assign w_take_right[g] = |(w_hit & UPTO);

            if (g == 0) begin : g_first
                assign w_left_lt[g] = 1'b1;
            end else begin : g_rest
                assign w_left_lt[g] = w_lt[g-1];
            end

            slt_cell #(
                .KEY_BITS (KEY_BITS)
            ) u_cell (
                .i_clk         (i_clk),
                .i_ctl         (w_ctl),
                .i_occupied    (w_occ[g]),
                .i_cmp_key     (i_word.key[KEY_BITS-1:0]),
                .i_cmp_value   (i_word.entry_value),
                .i_new_key     (r_key),
                .i_new_value   (r_value),
                .i_left_lt     (w_left_lt[g]),
                .i_left_key    ((g == 0) ? r_key : w_key[(g == 0) ? 0 : g - 1]),
                .i_left_value  ((g == 0) ? r_value : w_val[(g == 0) ? 0 : g - 1]),
                .i_right_key   (w_key[(g == CAPACITY - 1) ? g : g + 1]),
                .i_right_value (w_val[(g == CAPACITY - 1) ? g : g + 1]),
                .i_take_right  (w_take_right[g]),
                .o_lt          (w_lt[g]),
                .o_eq          (w_eq[g]),
                .o_vm          (w_vm[g]),
                .o_key         (w_key[g]),
                .o_value       (w_val[g])
            );
        end
    endgenerate

    assign w_any_eq  = |w_first_eq;
    assign w_any_hit = |w_hit;

    always_comb begin
        w_found = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            w_found = w_found | (w_val[i] & {VALUE_BITS{w_first_eq[i]}});
        end
    end

    always_comb begin
        w_do_ins        = 1'b0;
        w_do_del        = 1'b0;
        n_count         = r_count;
        n_out.status    = ST_MISS;
        n_out.found_value = '0;
        case (t_cmd'(r_cmd))
            CMD_INSERT: begin
                if (w_full) begin
                    n_out.status = ST_FULL;
                end else begin
                    w_do_ins     = 1'b1;
                    n_count      = r_count + CNT_W'(1);
                    n_out.status = ST_DONE;
                end
            end
            CMD_LOOKUP: begin
                if (w_any_eq) begin
                    n_out.status      = ST_DONE;
                    n_out.found_value = w_found;
                end
            end
            CMD_REMOVE: begin
                if (w_any_hit) begin
                    w_do_del     = 1'b1;
                    n_count      = r_count - CNT_W'(1);
                    n_out.status = ST_DONE;
                end
            end
            default: n_out.status = ST_MISS;
        endcase
        w_cnt_ext         = {{COUNT_FIELD_BITS{1'b0}}, n_count};
        n_out.entry_count = w_cnt_ext[COUNT_FIELD_BITS-1:0];
    end

    assign w_ctl.cmp_en = w_accept;
    assign w_ctl.ins    = w_commit && w_do_ins;
    assign w_ctl.del    = w_commit && w_do_del;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_commit) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd   <= i_word.command;
            r_key   <= i_word.key[KEY_BITS-1:0];
            r_value <= i_word.entry_value;
        end
        if (w_commit) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_word  = r_out;

    `SLT_CHK_NOW(a_count_max, 1'b1, r_count <= CNT_W'(CAPACITY), "entry count above capacity")
    `SLT_CHK_NEXT(a_accept_exec, w_accept, r_state == S_EXEC, "accepted word not executed")
    `SLT_CHK_NOW(a_first_eq_one, r_state == S_EXEC, $onehot0(w_first_eq), "several first-equal cells")
    `SLT_CHK_NEXT(a_count_step, w_commit, (r_count == $past(r_count)) || (r_count == $past(r_count) + CNT_W'(1)) || (r_count == $past(r_count) - CNT_W'(1)), "entry count jumped")

endmodule

`default_nettype wire
